### hdl/svn2d_pkg.sv
`default_nettype none
package svn2d_pkg;
    // Divider register stages (48 bit steps, 2 per stage) and stages after the divider
    localparam int unsigned DIV_STAGES      = 24;
    localparam int unsigned POST_DIV_STAGES = 8;

    localparam logic [31:0] MIX_KX   = 32'd374761393;
    localparam logic [31:0] MIX_KZ   = 32'd668265263;
    localparam logic [31:0] MIX_ADD  = 32'd20260509;
    localparam logic [31:0] MIX_KF   = 32'd1274126177;
    localparam logic [31:0] SEED_KX  = 32'd2246822519;
    localparam logic [31:0] SEED_KZ  = 32'd3266489917;
    localparam logic [31:0] SEED_KS  = 32'd747796405;

    typedef enum logic [1:0] {
        REG_FREQUENCY = 2'd0,
        REG_SALT      = 2'd1,
        REG_SEED      = 2'd2
    } reg_index_t;

    // Divider lane for both coordinates: remainder being reduced and quotient, for x and for z
    typedef struct packed {
        logic [31:0] rem_x;
        logic [31:0] quo_x;
        logic [31:0] rem_z;
        logic [31:0] quo_z;
    } div_lane_t;

    typedef struct packed {
        logic [31:0] cell_x;
        logic [31:0] cell_z;
        logic [15:0] frac_x;
        logic [15:0] frac_z;
    } cell_frac_t;
endpackage
`default_nettype wire

### hdl/svn2d_div.sv
`default_nettype none
// Pipelined restoring divider: 32 quotient steps then 16 fraction steps, 2 bits per stage.
module svn2d_div
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire logic [31:0]           pos_x,
    input  wire logic [31:0]           pos_z,
    input  wire logic [15:0]           divisor,
    output logic                       out_valid,
    output svn2d_pkg::cell_frac_t      result
);
    logic [svn2d_pkg::DIV_STAGES:1] vld_reg;
    logic [47:0]         nx_reg [1:svn2d_pkg::DIV_STAGES];
    logic [47:0]         nz_reg [1:svn2d_pkg::DIV_STAGES];
    logic [16:0]         rx_reg [1:svn2d_pkg::DIV_STAGES];
    logic [16:0]         rz_reg [1:svn2d_pkg::DIV_STAGES];
    logic [15:0]         d_reg  [1:svn2d_pkg::DIV_STAGES];

    function automatic void step2(input logic [16:0] r_in, input logic [47:0] n_in,
                                  input logic [15:0] d, output logic [16:0] r_out,
                                  output logic [47:0] n_out);
        logic [16:0] r;
        logic [47:0] n;
        logic [17:0] t;
        r = r_in;
        n = n_in;
        for (int k = 0; k < 2; k++)
        begin
            t = {r, n[47]};
            n = {n[46:0], 1'b0};
            if (t >= {2'b0, d})
            begin
                t = t - {2'b0, d};
                n[0] = 1'b1;
            end
            r = t[16:0];
        end
        r_out = r;
        n_out = n;
    endfunction

    for (genvar g = 1; g <= svn2d_pkg::DIV_STAGES; g++)
    begin : g_st
        logic        vld_cur;
        logic [16:0] rx_cur, rz_cur, rx_next, rz_next;
        logic [47:0] nx_cur, nz_cur, nx_next, nz_next;
        logic [15:0] d_cur;

        if (g == 1)
        begin : g_head
            assign vld_cur = in_valid;
            assign nx_cur  = {pos_x, 16'd0};
            assign nz_cur  = {pos_z, 16'd0};
            assign rx_cur  = '0;
            assign rz_cur  = '0;
            assign d_cur   = (divisor == 16'd0) ? 16'd1 : divisor;
        end
        else
        begin : g_body
            assign vld_cur = vld_reg[g-1];
            assign nx_cur  = nx_reg[g-1];
            assign nz_cur  = nz_reg[g-1];
            assign rx_cur  = rx_reg[g-1];
            assign rz_cur  = rz_reg[g-1];
            assign d_cur   = d_reg[g-1];
        end

        always_comb
        begin
            step2(rx_cur, nx_cur, d_cur, rx_next, nx_next);
            step2(rz_cur, nz_cur, d_cur, rz_next, nz_next);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[g] <= vld_cur;
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rx_reg[g] <= rx_next;
                rz_reg[g] <= rz_next;
                nx_reg[g] <= nx_next;
                nz_reg[g] <= nz_next;
                d_reg[g]  <= d_cur;
            end
        end
    end

    // After 48 steps the shifted-in bits form {cell, frac}
    assign out_valid     = vld_reg[svn2d_pkg::DIV_STAGES];
    assign result.cell_x = nx_reg[svn2d_pkg::DIV_STAGES][47:16];
    assign result.frac_x = nx_reg[svn2d_pkg::DIV_STAGES][15:0];
    assign result.cell_z = nz_reg[svn2d_pkg::DIV_STAGES][47:16];
    assign result.frac_z = nz_reg[svn2d_pkg::DIV_STAGES][15:0];
endmodule
`default_nettype wire

### hdl/svn2d_hash.sv
`default_nettype none
// Corner hash, three register stages (multiply, add, mix multiply); returns the high and low 16 bits XORed.
module svn2d_hash
(
    input  wire logic        clk,
    input  wire logic        advance,
    input  wire logic [31:0] hx,
    input  wire logic [31:0] hz,
    output logic      [15:0] value
);
    logic [31:0] px_reg, pz_reg, n_reg, m_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg <= hx * svn2d_pkg::MIX_KX;
            pz_reg <= hz * svn2d_pkg::MIX_KZ;
            n_reg  <= px_reg + pz_reg + svn2d_pkg::MIX_ADD;
            m_reg  <= (n_reg ^ (n_reg >> 13)) * svn2d_pkg::MIX_KF;
        end
    end

    assign value = m_reg[15:0] ^ m_reg[31:16];
endmodule
`default_nettype wire

### hdl/svn2d_blend.sv
`default_nettype none
// Smoothstep weights and bilinear blend, one multiply level per stage.
module svn2d_blend
(
    input  wire logic        clk,
    input  wire logic        advance,
    input  wire logic [15:0] frac_x,
    input  wire logic [15:0] frac_z,
    input  wire logic [15:0] v00,
    input  wire logic [15:0] v10,
    input  wire logic [15:0] v01,
    input  wire logic [15:0] v11,
    output logic      [15:0] blended
);
    // Stage 1: t*t, hold 3 - 2t and corners
    logic [15:0] tx2_reg, tz2_reg;
    logic [17:0] kx_reg, kz_reg;
    logic [15:0] a00_reg, a10_reg, a01_reg, a11_reg;
    // Stage 2: weights
    logic [15:0] wx_reg, wz_reg;
    logic [15:0] b00_reg, b10_reg, b01_reg, b11_reg;
    // Stage 3: products along x
    logic [32:0] p0_reg, p1_reg;
    logic [15:0] wz2_reg;
    // Stage 4: products along z
    logic [32:0] q_reg;

    logic [31:0] sqx, sqz;
    logic [33:0] wxf, wzf;
    logic [15:0] l0, l1;
    logic [16:0] iwx, iwz;

    always_comb
    begin
        sqx = frac_x * frac_x;
        sqz = frac_z * frac_z;
        wxf = tx2_reg * kx_reg;
        wzf = tz2_reg * kz_reg;
        iwx = 17'h10000 - {1'b0, wx_reg};
        iwz = 17'h10000 - {1'b0, wz2_reg};
        l0  = p0_reg[31:16];
        l1  = p1_reg[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx2_reg <= sqx[31:16];
            tz2_reg <= sqz[31:16];
            kx_reg  <= 18'd196608 - {1'b0, frac_x, 1'b0};
            kz_reg  <= 18'd196608 - {1'b0, frac_z, 1'b0};
            a00_reg <= v00; a10_reg <= v10; a01_reg <= v01; a11_reg <= v11;

            wx_reg  <= wxf[31:16];
            wz_reg  <= wzf[31:16];
            b00_reg <= a00_reg; b10_reg <= a10_reg; b01_reg <= a01_reg; b11_reg <= a11_reg;

            p0_reg  <= {17'd0, b00_reg} * {16'd0, iwx} + {17'd0, b10_reg} * {17'd0, wx_reg};
            p1_reg  <= {17'd0, b01_reg} * {16'd0, iwx} + {17'd0, b11_reg} * {17'd0, wx_reg};
            wz2_reg <= wz_reg;

            q_reg   <= {17'd0, l0} * {16'd0, iwz} + {17'd0, l1} * {17'd0, wz2_reg};
        end
    end

    assign blended = q_reg[31:16];
endmodule
`default_nettype wire

### hdl/seeded_value_noise_2d.sv
`default_nettype none
// Pipeline: 33 register stages from an accepted input to out_valid (24 divider,
// 1 corner, 3 hash, 4 blend, 1 output register).
// Throughput: one transaction per cycle unless in_stall; the 48-step divider sets the depth.
// Reset: rst_n clears valid bits and sets frequency=1, salt=0, seed=0.
module seeded_value_noise_2d
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] noise_value,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [15:0] freq_reg;
    logic [31:0] salt_reg, seed_reg;
    logic [31:0] ss_reg, skx_reg, skz_reg, sm_reg;

    // Config writes; derived seed products registered (stable while idle)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= 16'd1;
            salt_reg <= '0;
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (svn2d_pkg::reg_index_t'(cfg_index))
                svn2d_pkg::REG_FREQUENCY: freq_reg <= cfg_data[15:0];
                svn2d_pkg::REG_SALT:      salt_reg <= cfg_data;
                svn2d_pkg::REG_SEED:      seed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sm_reg  <= seed_reg * svn2d_pkg::SEED_KS;
        skx_reg <= seed_reg * svn2d_pkg::SEED_KX;
        skz_reg <= seed_reg * svn2d_pkg::SEED_KZ;
        ss_reg  <= salt_reg ^ sm_reg;
    end

    // Whole pipe advances together; stall only when output holds a result
    // and the skid register is also full.
    logic advance;
    logic out_full_reg, skid_full_reg;
    logic [15:0] out_data_reg, skid_data_reg;

    assign advance  = !skid_full_reg;
    assign in_stall = skid_full_reg;

    logic div_valid;
    svn2d_pkg::cell_frac_t cf;

    svn2d_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .pos_x     (pos_x),
        .pos_z     (pos_z),
        .divisor   (freq_reg),
        .out_valid (div_valid),
        .result    (cf)
    );

    // Corner stage: offset cells and apply seed
    logic [31:0] hx0_reg, hx1_reg, hz0_reg, hz1_reg;
    logic [15:0] fx_d [4];
    logic [15:0] fz_d [4];
    logic [svn2d_pkg::POST_DIV_STAGES-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hx0_reg  <= (cf.cell_x + ss_reg) ^ skx_reg;
            hx1_reg  <= (cf.cell_x + 32'd1 + ss_reg) ^ skx_reg;
            hz0_reg  <= (cf.cell_z + ss_reg) ^ skz_reg;
            hz1_reg  <= (cf.cell_z + 32'd1 + ss_reg) ^ skz_reg;
            fx_d[0]  <= cf.frac_x;
            fz_d[0]  <= cf.frac_z;
            for (int i = 1; i < 4; i++)
            begin
                fx_d[i] <= fx_d[i-1];
                fz_d[i] <= fz_d[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[svn2d_pkg::POST_DIV_STAGES-2:0], div_valid};
        end
    end

    logic [15:0] v00, v10, v01, v11, blended;
    svn2d_hash u_h00 (.clk(clk), .advance(advance), .hx(hx0_reg), .hz(hz0_reg), .value(v00));
    svn2d_hash u_h10 (.clk(clk), .advance(advance), .hx(hx1_reg), .hz(hz0_reg), .value(v10));
    svn2d_hash u_h01 (.clk(clk), .advance(advance), .hx(hx0_reg), .hz(hz1_reg), .value(v01));
    svn2d_hash u_h11 (.clk(clk), .advance(advance), .hx(hx1_reg), .hz(hz1_reg), .value(v11));

    // Hash output is aligned with the 4th fraction delay tap (1 corner + 3 hash)
    svn2d_blend u_blend
    (
        .clk     (clk),
        .advance (advance),
        .frac_x  (fx_d[3]),
        .frac_z  (fz_d[3]),
        .v00     (v00),
        .v10     (v10),
        .v01     (v01),
        .v11     (v11),
        .blended (blended)
    );

    // Blend result valid after corner(1) + hash(3) + blend(4) = 8 stages
    logic pipe_valid;
    assign pipe_valid = vld_reg[svn2d_pkg::POST_DIV_STAGES-1];

    // Output register with skid: a result entering while out is held parks in skid.
    logic take;
    assign take = out_full_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (skid_full_reg)
            begin
                if (take)
                begin
                    skid_full_reg <= 1'b0;
                end
            end
            else if (pipe_valid && out_full_reg && !take)
            begin
                skid_full_reg <= 1'b1;
            end
            if (take || !out_full_reg)
            begin
                out_full_reg <= skid_full_reg || (advance && pipe_valid);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && pipe_valid && out_full_reg && !take)
        begin
            skid_data_reg <= blended;
        end
        if (take || !out_full_reg)
        begin
            out_data_reg <= skid_full_reg ? skid_data_reg : blended;
        end
    end

    assign out_valid   = out_full_reg;
    assign noise_value = out_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_full_reg) else $error("skid full while output empty");
    a_stall_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == skid_full_reg) else $error("stall mismatch");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && !out_stall) |=> !skid_full_reg) else $error("skid not drained");
`endif
endmodule
`default_nettype wire

### test/tb_seeded_value_noise_2d.sv
`default_nettype none
module tb_seeded_value_noise_2d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] pos_x;
    logic [31:0] pos_z;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] noise_value;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    seeded_value_noise_2d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Shadow copy of the block's registers, used by the noise predictor
    logic [15:0] cell_size;
    logic [31:0] layer_salt;
    logic [31:0] gen_seed;

    // Points waiting to be offered, and noise values waiting to come out
    logic [31:0] point_x_q[$];
    logic [31:0] point_z_q[$];
    logic [15:0] noise_expected_q[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_off;
    int hold_off_cycles;
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit in_taken;

    function automatic logic [31:0] hash_corner(logic [31:0] cx, logic [31:0] cz,
                                                logic [31:0] s);
        logic [31:0] hx;
        logic [31:0] hz;
        logic [31:0] n;
        hx = cx ^ (s * svn2d_pkg::SEED_KX);
        hz = cz ^ (s * svn2d_pkg::SEED_KZ);
        n = hx * svn2d_pkg::MIX_KX + hz * svn2d_pkg::MIX_KZ + svn2d_pkg::MIX_ADD;
        n = (n ^ (n >> 13)) * svn2d_pkg::MIX_KF;
        return n ^ (n >> 16);
    endfunction

    function automatic logic [63:0] smoothstep_q16(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> 16;
        return (t2 * (64'd196608 - 2 * t)) >> 16;
    endfunction

    function automatic logic [63:0] blend_q16(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd65536 - w) + b * w) >> 16;
    endfunction

    function automatic logic [15:0] predict_noise(logic [31:0] px, logic [31:0] pz);
        logic [31:0] f;
        logic [31:0] cx;
        logic [31:0] cz;
        logic [63:0] tx;
        logic [63:0] tz;
        logic [31:0] ss;
        logic [63:0] v00, v10, v01, v11, wx, wz, r;
        f = (cell_size == 0) ? 32'd1 : {16'd0, cell_size};
        cx = px / f;
        cz = pz / f;
        tx = {32'd0, px % f} * 64'd65536 / f;
        tz = {32'd0, pz % f} * 64'd65536 / f;
        ss = layer_salt ^ (gen_seed * svn2d_pkg::SEED_KS);
        v00 = hash_corner(cx + ss, cz + ss, gen_seed) & 32'hFFFF;
        v10 = hash_corner(cx + 1 + ss, cz + ss, gen_seed) & 32'hFFFF;
        v01 = hash_corner(cx + ss, cz + 1 + ss, gen_seed) & 32'hFFFF;
        v11 = hash_corner(cx + 1 + ss, cz + 1 + ss, gen_seed) & 32'hFFFF;
        wx = smoothstep_q16(tx);
        wz = smoothstep_q16(tz);
        r = blend_q16(blend_q16(v00, v10, wx), blend_q16(v01, v11, wx), wz);
        return r[15:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: offer the oldest pending point; advance only on acceptance
    always @(negedge clk)
    begin
        if (in_taken)
        begin
            void'(point_x_q.pop_front());
            void'(point_z_q.pop_front());
        end
        if (rst_n && point_x_q.size() > 0 &&
            ((in_valid && !in_taken) || $urandom_range(99) >= sender_idle_pct))
        begin
            in_valid <= 1'b1;
            pos_x <= point_x_q[0];
            pos_z <= point_z_q[0];
        end
        else
        begin
            in_valid <= 1'b0;
        end
        out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                noise_expected_q.push_back(predict_noise(pos_x, pos_z));
            end
            if (out_valid && !out_stall)
            begin
                if (noise_expected_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected noise_value %0d", noise_value);
                end
                else
                begin
                    if (noise_value !== noise_expected_q[0])
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("noise_value expected %0d actual %0d",
                                     noise_expected_q[0], noise_value);
                    end
                    void'(noise_expected_q.pop_front());
                end
            end
        end
    end

    // Hold off the receiver for a counted stretch so the pipeline fills up
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            hold_off <= 1'b0;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("seeded_value_noise_2d: mismatch");
            $finish;
        end
    end

    task automatic write_reg(svn2d_pkg::reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            svn2d_pkg::REG_FREQUENCY: cell_size = value[15:0];
            svn2d_pkg::REG_SALT:      layer_salt = value;
            svn2d_pkg::REG_SEED:      gen_seed = value;
            default:       ;
        endcase
    endtask

    task automatic queue_point(logic [31:0] px, logic [31:0] pz);
        point_x_q.push_back(px);
        point_z_q.push_back(pz);
    endtask

    // Wait until every point is accepted and every value has come out
    task automatic drain();
        while (point_x_q.size() > 0 || noise_expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random points: anywhere, within four cell sizes of zero, or at cell edges
    task automatic queue_random(int count);
        logic [31:0] f;
        f = (cell_size == 0) ? 32'd1 : {16'd0, cell_size};
        repeat (count)
        begin
            case ($urandom_range(3))
                0: queue_point($urandom, $urandom);
                1: queue_point($urandom_range(f * 4), $urandom_range(f * 4));
                2: queue_point(32'hFFFFFFFF - $urandom_range(f * 2),
                               ($urandom / f) * f + f - 1);
                default: queue_point(($urandom / f) * f + $urandom_range(1),
                                     $urandom);
            endcase
        end
    endtask

    initial
    begin
        logic [31:0] settings[6][3];
        int idle_plan[4][2];
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_z = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = svn2d_pkg::REG_FREQUENCY;
        cfg_data = '0;
        cell_size = 16'd1;
        layer_salt = '0;
        gen_seed = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off = 1'b0;
        hold_off_cycles = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        in_taken = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset registers, coordinate extremes
        queue_point(32'd0, 32'd0);
        queue_point(32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_point(32'hFFFFFFFF, 32'd0);
        queue_point(32'h55555555, 32'hAAAAAAAA);
        drain();

        // Zero frequency is treated as a cell size of one
        write_reg(svn2d_pkg::REG_FREQUENCY, 32'd0);
        queue_point(32'd7, 32'hFFFFFFFF);
        queue_point(32'hAAAAAAAA, 32'h55555555);
        drain();

        // Largest cell size with all-ones salt and seed: wrapping cell + salt
        write_reg(svn2d_pkg::REG_FREQUENCY, 32'd65535);
        write_reg(svn2d_pkg::REG_SALT, 32'hFFFFFFFF);
        write_reg(svn2d_pkg::REG_SEED, 32'hFFFFFFFF);
        queue_point(32'd0, 32'd65534);
        queue_point(32'd65535, 32'd32767);
        queue_point(32'hFFFFFFFF, 32'hFFFEFFFF);
        queue_point(32'hFFFF0000, 32'd1);
        queue_point(32'd98302, 32'd131069);
        drain();

        write_reg(svn2d_pkg::REG_FREQUENCY, 32'd3);
        write_reg(svn2d_pkg::REG_SALT, 32'd0);
        write_reg(svn2d_pkg::REG_SEED, 32'h80000001);
        queue_point(32'd1, 32'd2);
        queue_point(32'd2, 32'd1);
        queue_point(32'hFFFFFFFE, 32'hFFFFFFFD);
        drain();

        settings = '{
            '{32'd1, 32'd0, 32'd0},
            '{32'd65535, 32'hFFFFFFFF, 32'hFFFFFFFF},
            '{32'd256, 32'h12345678, 32'h9ABCDEF0},
            '{32'd7, 32'h80000000, 32'd1},
            '{32'd0, 32'hDEADBEEF, 32'h00000000},
            '{32'd40000, 32'd0, 32'h7FFFFFFF}
        };
        idle_plan = '{'{0, 0}, '{61, 0}, '{0, 61}, '{36, 36}};

        for (int p = 0; p < 6; p++)
        begin
            write_reg(svn2d_pkg::REG_FREQUENCY, p == 5 ? $urandom : settings[p][0]);
            write_reg(svn2d_pkg::REG_SALT, p == 5 ? $urandom : settings[p][1]);
            write_reg(svn2d_pkg::REG_SEED, p == 5 ? $urandom : settings[p][2]);
            for (int k = 0; k < 4; k++)
            begin
                sender_idle_pct = idle_plan[k][0];
                receiver_stall_pct = idle_plan[k][1];
                queue_random(64);
                // Long receiver hold-off while the sender keeps offering
                if (p == 2 && k == 0)
                    hold_off_cycles = 300;
                drain();
            end
        end

        if (mismatches == 0)
            $display("seeded_value_noise_2d: match");
        else
            $display("seeded_value_noise_2d: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
hdl/svn2d_pkg.sv
hdl/svn2d_div.sv
hdl/svn2d_hash.sv
hdl/svn2d_blend.sv
hdl/seeded_value_noise_2d.sv
test/tb_seeded_value_noise_2d.sv
